FILE: design/ccs_pkg.sv
// Shared types and constants of the CC/CV charge supervisor.
// Used by ccs_step, the top level and the checker.
package ccs_pkg;

  // Status codes reported on the result channel.
  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_CHARGING   = 3'd1,
    ST_DONE       = 3'd2,
    ST_TIMEOUT    = 3'd3,
    ST_ABORT      = 3'd4,
    ST_DISCONNECT = 3'd5,
    ST_POWER      = 3'd6
  } status_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MIN_SENSE_LEVEL  = 3'd0,
    REG_DONE_CURRENT     = 3'd1,
    REG_FAN_ON_CURRENT   = 3'd2,
    REG_FAN_OFF_CURRENT  = 3'd3,
    REG_TRIM_HIGH_RAW    = 3'd4,
    REG_TRIM_FAR_LOW_RAW = 3'd5,
    REG_TRIM_LOW_RAW     = 3'd6,
    REG_INITIAL_TRIM     = 3'd7
  } cfg_reg_e;

  localparam logic [7:0]  START_SAMPLES     = 8'd4;
  localparam logic [7:0]  TRIM_HOLD_SAMPLES = 8'd4;
  localparam logic [13:0] TIMEOUT_SECONDS   = 14'd15240;
  localparam logic [13:0] SECONDS_MAX       = 14'h3FFF;
  localparam logic [7:0]  TRIM_JUMP_LIMIT   = 8'hF0;
  localparam logic [7:0]  TRIM_JUMP         = 8'h10;
  localparam logic [7:0]  TRIM_MAX          = 8'hFF;

  typedef struct packed {
    logic [11:0] min_sense_level;
    logic [7:0]  done_current;
    logic [7:0]  fan_on_current;
    logic [7:0]  fan_off_current;
    logic [11:0] trim_high_raw;
    logic [11:0] trim_far_low_raw;
    logic [11:0] trim_low_raw;
    logic [7:0]  initial_trim;
  } ccs_cfg_t;

  typedef struct packed {
    logic        start_req;
    logic        tick_1hz;
    logic        adc_ready;
    logic        long_press;
    logic        power_ok;
    logic        cv_phase;
    logic [7:0]  charge_current;
    logic [11:0] sense_raw;
    logic [11:0] battery_raw;
  } ccs_in_t;

  typedef struct packed {
    logic        charging;
    status_e     end_status;
    logic [13:0] seconds_count;
    logic [7:0]  sample_holdoff;
    logic [7:0]  trim_holdoff;
    logic [7:0]  trim_setting;
    logic        fan_state;
  } ccs_state_t;

  typedef struct packed {
    status_e     status;
    logic        charger_enable;
    logic        fan_drive;
    logic [7:0]  trim_value;
    logic        trim_changed;
    logic [13:0] elapsed_seconds;
  } ccs_res_t;

endpackage

FILE: design/ccs_step.sv
// Next-state and result logic for one charge supervisor event.
// Purely combinational; depends on ccs_pkg.
module ccs_step import ccs_pkg::*; (
  input  ccs_cfg_t   cfg_i,
  input  ccs_state_t state_i,
  input  ccs_in_t    item_i,
  output ccs_state_t state_o,
  output ccs_res_t   res_o
);

  ccs_state_t st;
  logic       changed;

  always_comb begin
    st      = state_i;
    changed = 1'b0;

    // start reloads everything, then the same event is processed
    if (item_i.start_req) begin
      st.charging       = 1'b1;
      st.end_status     = ST_CHARGING;
      st.seconds_count  = '0;
      st.sample_holdoff = START_SAMPLES;
      st.trim_holdoff   = TRIM_HOLD_SAMPLES;
      st.trim_setting   = cfg_i.initial_trim;
      st.fan_state      = 1'b0;
      changed           = 1'b1;
    end

    if (st.charging) begin
      if (!item_i.power_ok) begin
        st.charging   = 1'b0;
        st.fan_state  = 1'b0;
        st.end_status = ST_POWER;
      end else begin
        if (item_i.tick_1hz && st.seconds_count != SECONDS_MAX) begin
          st.seconds_count = st.seconds_count + 14'd1;
        end
        if (st.seconds_count >= TIMEOUT_SECONDS) begin
          st.charging   = 1'b0;
          st.fan_state  = 1'b0;
          st.end_status = ST_TIMEOUT;
        end else if (item_i.long_press) begin
          st.charging   = 1'b0;
          st.fan_state  = 1'b0;
          st.end_status = ST_ABORT;
        end else if (item_i.adc_ready) begin
          if (st.sample_holdoff != '0) begin
            st.sample_holdoff = st.sample_holdoff - 8'd1;
          end
          // skip samples until the start-up holdoff runs out
          if (st.sample_holdoff == '0) begin
            if (item_i.sense_raw < cfg_i.min_sense_level) begin
              st.charging   = 1'b0;
              st.fan_state  = 1'b0;
              st.end_status = ST_DISCONNECT;
            end else if (item_i.charge_current <= cfg_i.done_current) begin
              st.charging   = 1'b0;
              st.fan_state  = 1'b0;
              st.end_status = ST_DONE;
            end else begin
              if (item_i.charge_current >= cfg_i.fan_on_current) begin
                st.fan_state = 1'b1;
              end else if (item_i.charge_current <= cfg_i.fan_off_current) begin
                st.fan_state = 1'b0;
              end
              if (!item_i.cv_phase) begin
                st.trim_holdoff = TRIM_HOLD_SAMPLES;
              end else if (st.trim_holdoff != '0) begin
                st.trim_holdoff = st.trim_holdoff - 8'd1;
              end else if (item_i.battery_raw >= cfg_i.trim_high_raw &&
                           st.trim_setting != '0) begin
                st.trim_setting = st.trim_setting - 8'd1;
                st.trim_holdoff = TRIM_HOLD_SAMPLES;
                changed         = 1'b1;
              end else if (item_i.battery_raw <= cfg_i.trim_far_low_raw) begin
                // saturating jump; counts as an update even when pinned at max
                st.trim_setting = (st.trim_setting < TRIM_JUMP_LIMIT) ?
                                  st.trim_setting + TRIM_JUMP : TRIM_MAX;
                st.trim_holdoff = TRIM_HOLD_SAMPLES;
                changed         = 1'b1;
              end else if (item_i.battery_raw <= cfg_i.trim_low_raw &&
                           st.trim_setting != TRIM_MAX) begin
                st.trim_setting = st.trim_setting + 8'd1;
                st.trim_holdoff = TRIM_HOLD_SAMPLES;
                changed         = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  assign state_o               = st;
  // end_status tracks ST_CHARGING for the whole charge
  assign res_o.status          = st.end_status;
  assign res_o.charger_enable  = st.charging;
  assign res_o.fan_drive       = st.fan_state;
  assign res_o.trim_value      = st.trim_setting;
  assign res_o.trim_changed    = changed;
  assign res_o.elapsed_seconds = st.seconds_count;

endmodule

FILE: design/cc_cv_charge_supervisor_unit.sv
// CC/CV charge supervisor: top level with configuration registers,
// input stage, supervisor state and result register. Uses ccs_pkg, ccs_step.
//
// Usage:
//   Events enter on the in_valid_i/in_ready_o channel, one transaction per
//   event, and every event yields exactly one result transaction on
//   out_valid_o/out_ready_i. An event is captured in an input register; the
//   next cycle ccs_step evaluates it against the supervisor state, and the
//   state and the result register update together.
//   The result register and out_valid_o load on the edge that advances the
//   event out of the input register. Throughput: one event per cycle while
//   the receiver does not stall, since the state update between the input
//   and result registers is combinational.
//   When the receiver stalls, the result holds and the input register keeps
//   one more event; in_ready_o drops only when both are full.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i, one
//   register per cycle, by the user only while the unit is idle; the unit does not enforce it.
//   Reset clears the supervisor state to idle, loads the configuration
//   register defaults and empties both stages.
module cc_cv_charge_supervisor_unit import ccs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_req_i,
  input  logic        tick_1hz_i,
  input  logic        adc_ready_i,
  input  logic        long_press_i,
  input  logic        power_ok_i,
  input  logic        cv_phase_i,
  input  logic [7:0]  charge_current_i,
  input  logic [11:0] sense_raw_i,
  input  logic [11:0] battery_raw_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        charger_enable_o,
  output logic        fan_drive_o,
  output logic [7:0]  trim_value_o,
  output logic        trim_changed_o,
  output logic [13:0] elapsed_seconds_o
);

  ccs_cfg_t   cfg_q;
  ccs_in_t    in_q, in_d;
  logic       in_vld_q;
  ccs_state_t state_q, state_d;
  ccs_res_t   res_q, res_d;
  logic       out_vld_q;
  logic       advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_sense_level  <= 12'd0;
      cfg_q.done_current     <= 8'd0;
      cfg_q.fan_on_current   <= 8'd255;
      cfg_q.fan_off_current  <= 8'd0;
      cfg_q.trim_high_raw    <= 12'd4095;
      cfg_q.trim_far_low_raw <= 12'd0;
      cfg_q.trim_low_raw     <= 12'd0;
      cfg_q.initial_trim     <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_SENSE_LEVEL:  cfg_q.min_sense_level  <= cfg_data_i;
        REG_DONE_CURRENT:     cfg_q.done_current     <= cfg_data_i[7:0];
        REG_FAN_ON_CURRENT:   cfg_q.fan_on_current   <= cfg_data_i[7:0];
        REG_FAN_OFF_CURRENT:  cfg_q.fan_off_current  <= cfg_data_i[7:0];
        REG_TRIM_HIGH_RAW:    cfg_q.trim_high_raw    <= cfg_data_i;
        REG_TRIM_FAR_LOW_RAW: cfg_q.trim_far_low_raw <= cfg_data_i;
        REG_TRIM_LOW_RAW:     cfg_q.trim_low_raw     <= cfg_data_i;
        REG_INITIAL_TRIM:     cfg_q.initial_trim     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // advance the held event when the result register is free or draining
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  assign in_d.start_req      = start_req_i;
  assign in_d.tick_1hz       = tick_1hz_i;
  assign in_d.adc_ready      = adc_ready_i;
  assign in_d.long_press     = long_press_i;
  assign in_d.power_ok       = power_ok_i;
  assign in_d.cv_phase       = cv_phase_i;
  assign in_d.charge_current = charge_current_i;
  assign in_d.sense_raw      = sense_raw_i;
  assign in_d.battery_raw    = battery_raw_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_d;
    end
  end

  ccs_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (in_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.charging       <= 1'b0;
      state_q.end_status     <= ST_IDLE;
      state_q.seconds_count  <= '0;
      state_q.sample_holdoff <= '0;
      state_q.trim_holdoff   <= '0;
      state_q.trim_setting   <= '0;
      state_q.fan_state      <= 1'b0;
      out_vld_q              <= 1'b0;
    end else begin
      if (advance) begin
        state_q   <= state_d;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign status_o          = res_q.status;
  assign charger_enable_o  = res_q.charger_enable;
  assign fan_drive_o       = res_q.fan_drive;
  assign trim_value_o      = res_q.trim_value;
  assign trim_changed_o    = res_q.trim_changed;
  assign elapsed_seconds_o = res_q.elapsed_seconds;

endmodule

FILE: design/ccs_checker.sv
// Port-level checks for the CC/CV charge supervisor, bound to the top level.
// Depends on ccs_pkg and cc_cv_charge_supervisor_unit.
module ccs_checker import ccs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic        charger_enable_o,
  input logic        fan_drive_o,
  input logic [7:0]  trim_value_o,
  input logic        trim_changed_o,
  input logic [13:0] elapsed_seconds_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(trim_value_o) && $stable(elapsed_seconds_o) && $stable(fan_drive_o))
    else $error("result changed while stalled");

  a_enable_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (charger_enable_o == (status_o == ST_CHARGING)))
    else $error("charger enable disagrees with status");

  a_fan_off_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !charger_enable_o |-> !fan_drive_o)
    else $error("fan on while not charging");

  // no charge has run yet, so nothing may have moved
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_IDLE |->
    !trim_changed_o && trim_value_o == '0 && elapsed_seconds_o == '0)
    else $error("idle result carries charge data");

endmodule

bind cc_cv_charge_supervisor_unit ccs_checker u_ccs_checker (.*);

FILE: tb/charge_tracker_pkg.sv
// Expected-outcome tracker for the CC/CV charge supervisor testbench.
// Holds its own copy of the supervisor state and configuration; depends on ccs_pkg.
package charge_tracker_pkg;
  import ccs_pkg::*;

  class charge_tracker;
    ccs_cfg_t    cfg;
    bit          charging;
    status_e     end_code;
    logic [13:0] secs;
    logic [7:0]  sample_hold;
    logic [7:0]  trim_hold;
    logic [7:0]  trim;
    bit          fan;
    bit          trim_touched;
    ccs_res_t    expected_outcomes[$];
    int          faults;

    function new();
      cfg = '{12'd0, 8'd0, 8'hFF, 8'd0, 12'hFFF, 12'd0, 12'd0, 8'd0};
      charging     = 1'b0;
      end_code     = ST_IDLE;
      secs         = '0;
      sample_hold  = '0;
      trim_hold    = '0;
      trim         = '0;
      fan          = 1'b0;
      trim_touched = 1'b0;
      faults       = 0;
    endfunction

    function void end_charge(status_e code);
      charging = 1'b0;
      fan      = 1'b0;
      end_code = code;
    endfunction

    // Walk one event through the supervisor while a charge runs.
    function void apply_event(ccs_in_t ev);
      if (!ev.power_ok) begin
        end_charge(ST_POWER);
        return;
      end
      if (ev.tick_1hz && secs != SECONDS_MAX) secs = secs + 14'd1;
      if (secs >= TIMEOUT_SECONDS) begin
        end_charge(ST_TIMEOUT);
        return;
      end
      if (ev.long_press) begin
        end_charge(ST_ABORT);
        return;
      end
      if (!ev.adc_ready) return;
      if (sample_hold != 8'd0) sample_hold = sample_hold - 8'd1;
      if (sample_hold != 8'd0) return;
      if (ev.sense_raw < cfg.min_sense_level) begin
        end_charge(ST_DISCONNECT);
        return;
      end
      if (ev.charge_current <= cfg.done_current) begin
        end_charge(ST_DONE);
        return;
      end
      if (ev.charge_current >= cfg.fan_on_current) fan = 1'b1;
      else if (ev.charge_current <= cfg.fan_off_current) fan = 1'b0;
      if (ev.cv_phase) begin
        if (trim_hold != 8'd0) begin
          trim_hold = trim_hold - 8'd1;
          return;
        end
        if (ev.battery_raw >= cfg.trim_high_raw && trim != 8'd0) begin
          trim = trim - 8'd1;
        end else if (ev.battery_raw <= cfg.trim_far_low_raw) begin
          trim = (trim < TRIM_JUMP_LIMIT) ? trim + TRIM_JUMP : TRIM_MAX;
        end else if (ev.battery_raw <= cfg.trim_low_raw && trim != TRIM_MAX) begin
          trim = trim + 8'd1;
        end else begin
          return;
        end
        trim_hold    = TRIM_HOLD_SAMPLES;
        trim_touched = 1'b1;
      end else begin
        trim_hold = TRIM_HOLD_SAMPLES;
      end
    endfunction

    function void note_event(ccs_in_t ev);
      ccs_res_t want;
      trim_touched = 1'b0;
      if (ev.start_req) begin
        charging     = 1'b1;
        end_code     = ST_CHARGING;
        secs         = '0;
        sample_hold  = START_SAMPLES;
        trim_hold    = TRIM_HOLD_SAMPLES;
        trim         = cfg.initial_trim;
        fan          = 1'b0;
        trim_touched = 1'b1;
      end
      if (charging) apply_event(ev);
      want.status          = charging ? ST_CHARGING : end_code;
      want.charger_enable  = charging;
      want.fan_drive       = fan;
      want.trim_value      = trim;
      want.trim_changed    = trim_touched;
      want.elapsed_seconds = secs;
      expected_outcomes.push_back(want);
    endfunction

    function void check_outcome(ccs_res_t got);
      ccs_res_t want;
      if (expected_outcomes.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("outcome with nothing outstanding: status %0d trim %0d seconds %0d",
                   got.status, got.trim_value, got.elapsed_seconds);
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.status !== want.status || got.charger_enable !== want.charger_enable ||
          got.fan_drive !== want.fan_drive || got.trim_value !== want.trim_value ||
          got.trim_changed !== want.trim_changed ||
          got.elapsed_seconds !== want.elapsed_seconds) begin
        faults++;
        if (faults <= 10)
          $display({"mismatch exp/got: status %0d/%0d enable %0d/%0d fan %0d/%0d ",
                    "trim %0d/%0d changed %0d/%0d seconds %0d/%0d"},
                   want.status, got.status, want.charger_enable, got.charger_enable,
                   want.fan_drive, got.fan_drive, want.trim_value, got.trim_value,
                   want.trim_changed, got.trim_changed,
                   want.elapsed_seconds, got.elapsed_seconds);
      end
    endfunction
  endclass

endpackage

FILE: tb/cc_cv_charge_supervisor_unit_tb.sv
// Top-level testbench of cc_cv_charge_supervisor_unit: directed events and random charges
// under several register settings. Uses ccs_pkg, charge_tracker_pkg.
module cc_cv_charge_supervisor_unit_tb;
  import ccs_pkg::*;
  import charge_tracker_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  cfg_reg_e    cfg_idx   = REG_MIN_SENSE_LEVEL;
  logic [11:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  ccs_in_t     ev_drv    = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic        charger_enable;
  logic        fan_drive;
  logic [7:0]  trim_value;
  logic        trim_changed;
  logic [13:0] elapsed_seconds;

  charge_tracker sb;
  ccs_cfg_t      cur_cfg;
  bit            steady      = 1'b0;
  int            burst_left  = 0;
  int            stall_left  = 0;
  int            idle_cycles = 0;

  cc_cv_charge_supervisor_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .start_req_i      (ev_drv.start_req),
    .tick_1hz_i       (ev_drv.tick_1hz),
    .adc_ready_i      (ev_drv.adc_ready),
    .long_press_i     (ev_drv.long_press),
    .power_ok_i       (ev_drv.power_ok),
    .cv_phase_i       (ev_drv.cv_phase),
    .charge_current_i (ev_drv.charge_current),
    .sense_raw_i      (ev_drv.sense_raw),
    .battery_raw_i    (ev_drv.battery_raw),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .charger_enable_o (charger_enable),
    .fan_drive_o      (fan_drive),
    .trim_value_o     (trim_value),
    .trim_changed_o   (trim_changed),
    .elapsed_seconds_o(elapsed_seconds)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: ready most cycles, with random stall runs unless the phase is steady.
  always @(posedge clk_i) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left <= int'($urandom_range(1, 9));
    end
  end

  always @(posedge clk_i) begin : outcome_check
    ccs_res_t got;
    if (rst_ni && out_valid && out_ready) begin
      got.status          = status_e'(status);
      got.charger_enable  = charger_enable;
      got.fan_drive       = fan_drive;
      got.trim_value      = trim_value;
      got.trim_changed    = trim_changed;
      got.elapsed_seconds = elapsed_seconds;
      sb.check_outcome(got);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("cc_cv_charge_supervisor_unit_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_event(ccs_in_t ev);
    int gap;
    if (!steady && burst_left == 0) begin
      gap        = int'($urandom_range(1, 12));
      burst_left = int'($urandom_range(1, 40));
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    ev_drv   <= ev;
    do @(posedge clk_i); while (!in_ready);
    sb.note_event(ev);
  endtask

  // Drain every outstanding transaction, then write all eight registers.
  task automatic load_config(ccs_cfg_t c);
    cfg_reg_e    r;
    logic [11:0] word;
    in_valid <= 1'b0;
    while (sb.expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    r = REG_MIN_SENSE_LEVEL;
    cfg_we <= 1'b1;
    repeat (8) begin
      case (r)
        REG_MIN_SENSE_LEVEL:  word = c.min_sense_level;
        REG_DONE_CURRENT:     word = {4'($urandom), c.done_current};
        REG_FAN_ON_CURRENT:   word = {4'($urandom), c.fan_on_current};
        REG_FAN_OFF_CURRENT:  word = {4'($urandom), c.fan_off_current};
        REG_TRIM_HIGH_RAW:    word = c.trim_high_raw;
        REG_TRIM_FAR_LOW_RAW: word = c.trim_far_low_raw;
        REG_TRIM_LOW_RAW:     word = c.trim_low_raw;
        default:              word = {4'($urandom), c.initial_trim};
      endcase
      cfg_idx  <= r;
      cfg_data <= word;
      @(posedge clk_i);
      r = r.next();
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
    sb.cfg  = c;
  endtask

  function automatic ccs_in_t make_ev(bit st, bit tk, bit adc, bit lp, bit pw, bit cv,
                                      logic [7:0] cur, logic [11:0] sense,
                                      logic [11:0] bat);
    ccs_in_t ev;
    ev = '{st, tk, adc, lp, pw, cv, cur, sense, bat};
    return ev;
  endfunction

  function automatic ccs_cfg_t rand_cfg();
    ccs_cfg_t    c;
    logic [11:0] t;
    c.min_sense_level  = 12'($urandom_range(0, 1023));
    c.done_current     = 8'($urandom_range(0, 63));
    c.fan_on_current   = 8'($urandom);
    c.fan_off_current  = 8'($urandom);
    c.trim_high_raw    = 12'($urandom);
    c.trim_far_low_raw = 12'($urandom);
    c.trim_low_raw     = 12'($urandom);
    c.initial_trim     = 8'($urandom);
    // Order the trim thresholds half of the time so every trim branch gets hit.
    if ($urandom_range(0, 1) == 0) begin
      if (c.trim_far_low_raw > c.trim_low_raw) begin
        t = c.trim_far_low_raw; c.trim_far_low_raw = c.trim_low_raw; c.trim_low_raw = t;
      end
      if (c.trim_low_raw > c.trim_high_raw) begin
        t = c.trim_low_raw; c.trim_low_raw = c.trim_high_raw; c.trim_high_raw = t;
      end
      if (c.trim_far_low_raw > c.trim_low_raw) begin
        t = c.trim_far_low_raw; c.trim_far_low_raw = c.trim_low_raw; c.trim_low_raw = t;
      end
    end
    return c;
  endfunction

  // Mostly well-formed charge events with random content, some pure noise.
  function automatic ccs_in_t pick_event();
    ccs_in_t     ev;
    logic [63:0] bits;
    int          roll;
    int          thr;
    bits = {$urandom, $urandom};
    ev   = bits[37:0];
    roll = int'($urandom_range(0, 99));
    if (roll < 10) begin
      ev.start_req = ($urandom_range(0, 7) == 0);
      return ev;
    end
    if (!sb.charging) ev.start_req = (roll < 92);
    else ev.start_req = ($urandom_range(0, 99) == 0);
    ev.adc_ready  = ($urandom_range(0, 9) < 7);
    ev.long_press = ($urandom_range(0, 149) == 0);
    ev.power_ok   = ($urandom_range(0, 149) != 0);
    ev.cv_phase   = ($urandom_range(0, 9) < 6);
    if ($urandom_range(0, 39) != 0 && cur_cfg.done_current != 8'hFF)
      ev.charge_current = 8'($urandom_range(255, int'(cur_cfg.done_current) + 1));
    if ($urandom_range(0, 59) != 0)
      ev.sense_raw = 12'($urandom_range(4095, int'(cur_cfg.min_sense_level)));
    case ($urandom_range(0, 4))
      1: thr = int'(cur_cfg.trim_high_raw);
      2: thr = int'(cur_cfg.trim_far_low_raw);
      3: thr = int'(cur_cfg.trim_low_raw);
      default: thr = -1;
    endcase
    if (thr >= 0) begin
      // Land on or next to a trim threshold.
      thr = thr + int'($urandom_range(0, 4)) - 2;
      if (thr < 0) thr = 0;
      else if (thr > 4095) thr = 4095;
      ev.battery_raw = 12'(thr);
    end
    return ev;
  endfunction

  task automatic run_phase(ccs_cfg_t c, bit calm, int target);
    int      counted;
    ccs_in_t ev;
    load_config(c);
    steady  = calm;
    counted = 0;
    while (counted < target) begin
      ev = pick_event();
      if (ev.start_req || sb.charging) counted++;
      send_event(ev);
    end
  endtask

  initial begin
    sb = new();
    cur_cfg = sb.cfg;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    load_config('{12'd200, 8'd20, 8'd180, 8'd60, 12'd3000, 12'd1000, 12'd2000, 8'd240});
    // Idle event without a start: ignored.
    send_event(make_ev(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 12'd4095, 12'd4095));
    // Start and lose power on the same event.
    send_event(make_ev(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 12'd0, 12'd0));
    send_event(make_ev(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 12'd0, 12'd0));
    // Sample holdoff, trim holdoff, jump to full scale, then jump again at full scale.
    repeat (8)
      send_event(make_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'd255, 12'd4095, 12'd0));
    repeat (5)
      send_event(make_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'd255, 12'd4095, 12'd0));
    repeat (4)
      send_event(make_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'd255, 12'd4095, 12'd0));
    // Step down with the fan dropping out, then done at zero current.
    send_event(make_ev(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'd40, 12'd4095, 12'd4095));
    send_event(make_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'd0, 12'd4095, 12'd2500));
    // Start and abort by key on the same event.
    send_event(make_ev(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'd128, 12'd2048, 12'd2048));

    run_phase('{12'd200, 8'd20, 8'd180, 8'd60, 12'd3000, 12'd1000, 12'd2000, 8'd240},
              1'b0, 195);
    run_phase('0, 1'b0, 195);
    run_phase('1, 1'b1, 195);
    run_phase('{12'd0, 8'd0, 8'hFF, 8'd0, 12'hFFF, 12'd0, 12'd0, 8'd0}, 1'b0, 195);
    run_phase('{12'd100, 8'd10, 8'd128, 8'd127, 12'd3500, 12'd1500, 12'd2500, 8'd255},
              1'b0, 195);
    run_phase(rand_cfg(), 1'b1, 195);
    run_phase(rand_cfg(), 1'b0, 195);
    run_phase(rand_cfg(), 1'b0, 195);

    in_valid <= 1'b0;
    while (sb.expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.faults == 0 && sb.expected_outcomes.size() == 0) begin
      $display("cc_cv_charge_supervisor_unit_tb: clean");
    end else begin
      $display("cc_cv_charge_supervisor_unit_tb: errors");
    end
    $finish;
  end

endmodule
